/* rtl/wms_pkg.sv */
// Shared types and constants for the windowed metric statistics block.
package wms_pkg;

    // Action codes carried in the input word.
    localparam logic [2:0] ACT_RECORD      = 3'd0;
    localparam logic [2:0] ACT_COMMIT      = 3'd1;
    localparam logic [2:0] ACT_RESET_FRAME = 3'd2;
    localparam logic [2:0] ACT_QUERY       = 3'd3;
    localparam logic [2:0] ACT_CLEAR       = 3'd4;

    // Window register.
    localparam int          WIN_W     = 7;
    localparam logic [6:0]  WIN_RESET = 7'd64;

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         metric_index;
        logic signed [23:0] duration;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] current_value;
        logic [30:0]        minimum_value;
        logic [30:0]        maximum_value;
        logic [30:0]        average_value;
        logic [6:0]         sample_count;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic take;
        logic commit_step;
        logic scan_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic query_empty;
        logic commit_last;
        logic scan_last;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/wms_datapath.sv */
// Datapath: accumulators, history memory, scan statistics, divider and output register.
module wms_datapath #(
    parameter int NUM_METRICS = 6,
    parameter int MAX_WINDOW  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wms_pkg::t_dp_cmd    i_cmd,
    output wms_pkg::t_dp_sts    o_sts,
    input  wms_pkg::t_in_word   i_in_word,
    input  logic                i_cfg_wr_en,
    input  logic [6:0]          i_cfg_wr_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output wms_pkg::t_out_word  o_out_word
);
    import wms_pkg::*;

    localparam int MW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
    localparam int HW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int EW    = (CW > WIN_W) ? CW : WIN_W;
    localparam int AW    = HW + MW;
    localparam int DEPTH = MAX_WINDOW << MW;

    // The sum of up to MAX_WINDOW positive 31-bit values, and a divider sized to match.
    localparam int SUM_W     = 31 + CW;
    localparam int DIV_STEPS = SUM_W;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);
    localparam int REM_W     = CW;

    // Frame accumulators and control state.
    logic signed [31:0] r_acc [NUM_METRICS];
    logic [MW-1:0]      r_cidx;
    logic [HW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [WIN_W-1:0]   r_win_cfg;

    // History memory.
    logic [31:0]        mem [DEPTH];
    logic [31:0]        r_rd_data;

    // Scan state.
    logic [MW-1:0]      r_metric;
    logic [HW-1:0]      r_slot;
    logic [CW-1:0]      r_left;
    logic               r_first_pend;
    logic               r_rd_vld;
    logic               r_rd_first;

    // Statistics.
    logic signed [31:0] r_cur;
    logic [30:0]        r_min;
    logic [30:0]        r_max;
    logic [SUM_W-1:0]   r_sum;
    logic [CW-1:0]      r_cnt;

    // Divider.
    logic [SUM_W-1:0]   r_num;
    logic [REM_W-1:0]   r_rem;
    logic [DSTEP_W-1:0] r_dstep;

    logic               r_out_vld;
    t_out_word          r_out;

    logic [MW-1:0]      in_metric;
    logic               in_metric_ok;
    logic [EW-1:0]      cfg_ext;
    logic [CW-1:0]      win;
    logic [CW-1:0]      n_frames;
    logic [MW-1:0]      acc_addr;
    logic signed [31:0] acc_rd;
    logic signed [32:0] rec_sum;
    logic signed [31:0] rec_sat;
    logic [CW:0]        cnt_inc;
    logic [HW-1:0]      slot_dec;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic               v_pos;
    logic [REM_W:0]     div_try;
    logic [REM_W:0]     div_den;
    logic               div_ge;
    logic               out_free;

    assign in_metric    = MW'(i_in_word.metric_index);
    assign in_metric_ok = (32'(i_in_word.metric_index) < NUM_METRICS);

    // Out-of-range window settings are clamped to 1..MAX_WINDOW.
    always_comb begin
        cfg_ext = EW'(r_win_cfg);
        if (cfg_ext == '0) begin
            win = CW'(1);
        end else if (cfg_ext > EW'(MAX_WINDOW)) begin
            win = CW'(MAX_WINDOW);
        end else begin
            win = CW'(cfg_ext);
        end
    end

    assign n_frames = (r_count > win) ? win : r_count;
    assign cnt_inc  = {1'b0, r_count} + (CW+1)'(1);

    // One read port on the accumulators, shared by record and commit.
    assign acc_addr = i_cmd.commit_step ? r_cidx : in_metric;
    assign acc_rd   = r_acc[acc_addr];
    assign rec_sum  = {acc_rd[31], acc_rd} + 33'(i_in_word.duration);

    always_comb begin
        if (rec_sum[32] != rec_sum[31]) begin
            rec_sat = rec_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            rec_sat = rec_sum[31:0];
        end
    end

    assign slot_dec = (r_slot == '0) ? HW'(MAX_WINDOW - 1) : r_slot - HW'(1);
    assign rd_addr  = {slot_dec, r_metric};
    assign mem_we   = i_cmd.commit_step;
    assign wr_addr  = {r_head, r_cidx};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= acc_rd;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Accumulators, ring pointer, fill count and window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_METRICS; i++) begin
                r_acc[i] <= '0;
            end
            r_cidx    <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_win_cfg <= WIN_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_win_cfg <= i_cfg_wr_data;
            end
            if (i_cmd.take) begin
                case (i_in_word.action)
                    ACT_RECORD: begin
                        if (in_metric_ok) begin
                            r_acc[in_metric] <= rec_sat;
                        end
                    end
                    ACT_COMMIT: r_cidx <= '0;
                    ACT_RESET_FRAME: begin
                        for (int i = 0; i < NUM_METRICS; i++) begin
                            r_acc[i] <= '0;
                        end
                    end
                    ACT_CLEAR: r_count <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.commit_step) begin
                r_cidx <= r_cidx + MW'(1);
                if (o_sts.commit_last) begin
                    r_head  <= (r_head == HW'(MAX_WINDOW - 1)) ? '0 : r_head + HW'(1);
                    r_count <= (cnt_inc > {1'b0, win}) ? win : cnt_inc[CW-1:0];
                end
            end
        end
    end

    // Scan control: reads go out one per cycle, data returns in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld     <= 1'b0;
            r_rd_first   <= 1'b0;
            r_first_pend <= 1'b0;
            r_left       <= '0;
            r_slot       <= '0;
            r_metric     <= '0;
        end else begin
            r_rd_vld   <= i_cmd.scan_step;
            r_rd_first <= i_cmd.scan_step & r_first_pend;
            if (i_cmd.take) begin
                r_metric     <= in_metric;
                r_slot       <= r_head;
                r_left       <= n_frames;
                r_first_pend <= 1'b1;
            end else if (i_cmd.scan_step) begin
                r_slot       <= slot_dec;
                r_left       <= r_left - CW'(1);
                r_first_pend <= 1'b0;
            end
        end
    end

    assign v_pos = !r_rd_data[31] && (r_rd_data != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cur <= '0;
            r_min <= '0;
            r_max <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_rd_vld) begin
            if (r_rd_first) begin
                r_cur <= r_rd_data;
            end
            if (v_pos) begin
                r_sum <= r_sum + SUM_W'(r_rd_data[30:0]);
                if (r_cnt == '0 || r_rd_data[30:0] < r_min) begin
                    r_min <= r_rd_data[30:0];
                end
                if (r_cnt == '0 || r_rd_data[30:0] > r_max) begin
                    r_max <= r_rd_data[30:0];
                end
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Restoring divider, one quotient bit per cycle; the quotient shifts into r_num.
    assign div_den = {1'b0, REM_W'(r_cnt)};
    assign div_try = {r_rem, r_num[SUM_W-1]};
    assign div_ge  = (div_try >= div_den);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num   <= r_sum;
            r_rem   <= '0;
            r_dstep <= '0;
        end else if (i_cmd.div_step) begin
            r_num   <= {r_num[SUM_W-2:0], div_ge};
            r_rem   <= div_ge ? REM_W'(div_try - div_den) : div_try[REM_W-1:0];
            r_dstep <= r_dstep + DSTEP_W'(1);
        end
    end

    // Output register.
    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load && out_free) begin
            r_out.current_value <= r_cur;
            r_out.minimum_value <= r_min;
            r_out.maximum_value <= r_max;
            r_out.average_value <= (r_cnt == '0) ? '0 : r_num[30:0];
            r_out.sample_count  <= 7'(r_cnt);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    assign o_sts.query_empty = !in_metric_ok || (r_count == '0);
    assign o_sts.commit_last = (r_cidx == MW'(NUM_METRICS - 1));
    assign o_sts.scan_last   = (r_left == CW'(1));
    assign o_sts.div_last    = (r_dstep == DSTEP_W'(DIV_STEPS - 1));
    assign o_sts.out_free    = out_free;

endmodule

/* rtl/wms_ctrl.sv */
// Controller state machine that sequences commits, query scans and the divider.
module wms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_action,
    input  wms_pkg::t_dp_sts i_sts,
    output wms_pkg::t_dp_cmd o_cmd,
    output logic             o_in_stall
);
    import wms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        ACT_COMMIT: n_state = ST_COMMIT;
                        ACT_QUERY:  n_state = i_sts.query_empty ? ST_FINISH : ST_SCAN;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_COMMIT:   if (i_sts.commit_last) n_state = ST_IDLE;
            ST_SCAN:     if (i_sts.scan_last) n_state = ST_DRAIN;
            ST_DRAIN:    n_state = ST_DIV_LOAD;
            ST_DIV_LOAD: n_state = ST_DIVIDE;
            ST_DIVIDE:   if (i_sts.div_last) n_state = ST_FINISH;
            ST_FINISH:   if (i_sts.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            ST_COMMIT:   o_cmd.commit_step = 1'b1;
            ST_SCAN:     o_cmd.scan_step   = 1'b1;
            ST_DRAIN:    ;
            ST_DIV_LOAD: o_cmd.div_load    = 1'b1;
            ST_DIVIDE:   o_cmd.div_step    = 1'b1;
            ST_FINISH:   o_cmd.out_load    = 1'b1;
            default:     ;
        endcase
    end

endmodule

/* rtl/windowed_metric_stats.sv */
// Top level of the windowed per-metric timing statistics block.
//
// Input words carry an action, a metric index and a signed duration in
// 1/256 ms. Record, reset-frame and clear words finish in the cycle they are
// accepted. A commit copies one accumulator per cycle into the history
// memory and stalls the input until all NUM_METRICS accumulators are copied.
// A query reads one history frame per cycle from the memory port, then runs
// a restoring divider for the average. A query on an empty history or an
// invalid metric skips the scan and the divider and returns all-zero fields.
// Only a query produces an output word. The block works on one word at a
// time and stalls its input meanwhile. The result sits in an output
// register, so a stalled receiver holds only the next query's completion,
// not earlier work. Reset clears the accumulators and empties the history,
// and sets the window register to 64. The window register may be written
// only while the block is idle.
module windowed_metric_stats #(
    parameter int NUM_METRICS = 6,
    parameter int MAX_WINDOW  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wms_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wms_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_wr_en,
    input  logic [6:0]          i_cfg_wr_data
);
    import wms_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    wms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_word.action),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    wms_datapath #(
        .NUM_METRICS (NUM_METRICS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_word     (i_in_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word)
    );

endmodule
